// ===== design/gda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder package
// Field widths, calendar constants, operation and status codes, the
// micro-operation set and the condition group shared by the sequencer and
// the datapath.
// ----------------------------------------------------------------------------
package gda_pkg;

  // Field widths of the request and result transactions.
  localparam int OP_W   = 3;
  localparam int AMT_W  = 16;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int ST_W   = 2;

  // Internal widths. The working year must hold the largest input year plus
  // ten times the largest amount.
  localparam int YW     = 20;
  localparam int CNT_W  = 19;
  localparam int MOD_W  = 9;
  localparam int YLO_W  = 17;
  localparam int PROD_W = 34;
  localparam int PC_W   = 5;

  // Year modulo 400 by reciprocal: q = (y * RECIP) >> RECIP_SHIFT is exact
  // for every year below 91180.
  localparam logic [YLO_W-1:0] RECIP       = 17'd83887;
  localparam int               RECIP_SHIFT = 25;
  localparam logic [YLO_W-1:0] CYCLE_400   = 17'd400;
  localparam logic [MOD_W-1:0] MOD_LAST    = 9'd399;
  localparam logic [MOD_W-1:0] CENT_1      = 9'd100;
  localparam logic [MOD_W-1:0] CENT_2      = 9'd200;
  localparam logic [MOD_W-1:0] CENT_3      = 9'd300;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST    = 5'd1;
  localparam logic [DAY_W-1:0] DAY_FEB_LEAP = 5'd29;
  localparam logic [DAY_W-1:0] DAY_FEB_STD  = 5'd28;
  localparam logic [DAY_W-1:0] DAY_DEC_LAST = 5'd31;

  localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Operation codes.
  localparam logic [OP_W-1:0] OP_DAYS    = 3'd0;
  localparam logic [OP_W-1:0] OP_WEEKS   = 3'd1;
  localparam logic [OP_W-1:0] OP_MONTHS  = 3'd2;
  localparam logic [OP_W-1:0] OP_YEARS   = 3'd3;
  localparam logic [OP_W-1:0] OP_DECADES = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

  // Micro-operations carried out by the datapath.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_MOD,
    UOP_CHECK,
    UOP_DAYSTEP,
    UOP_MONSTEP,
    UOP_YADD,
    UOP_YMUL,
    UOP_FEB,
    UOP_SAT,
    UOP_OUT
  } uop_t;

  // Jump conditions selected by a control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_INVALID,
    C_OP_DAY,
    C_OP_MON,
    C_OP_YR,
    C_LOOP_BUSY,
    C_OUT_BUSY
  } cond_sel_t;

  typedef struct packed {
    uop_t             uop;
    cond_sel_t        cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  // Status flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic invalid;
    logic op_day;
    logic op_mon;
    logic op_yr;
    logic loop_busy;
    logic out_busy;
  } cond_t;

  // Leap year from the year modulo 400.
  function automatic logic leap400(input logic [MOD_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3);
  endfunction

  // Length of a month; zero for a month number that means nothing.
  function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m,
                                               input logic lp);
    logic [DAY_W-1:0] len;
    len = 5'd0;
    if (m == MON_FEB) begin
      len = lp ? DAY_FEB_LEAP : DAY_FEB_STD;
    end else if (m >= MON_JAN && m <= MON_DEC) begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

// ===== design/gda_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder request channel
// Valid/ready channel carrying the operation, the amount and the start date.
// ----------------------------------------------------------------------------
interface gda_in_if;
  import gda_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [AMT_W-1:0]  amount;
  logic [DAY_W-1:0]  in_day;
  logic [MON_W-1:0]  in_month;
  logic [YEAR_W-1:0] in_year;

  modport source (output valid, op, amount, in_day, in_month, in_year, input ready);
  modport sink (input valid, op, amount, in_day, in_month, in_year, output ready);
endinterface

// ===== design/gda_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder result channel
// Valid/ready channel carrying the shifted date and its status.
// ----------------------------------------------------------------------------
interface gda_out_if;
  import gda_pkg::*;

  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  out_day;
  logic [MON_W-1:0]  out_month;
  logic [YEAR_W-1:0] out_year;
  logic [ST_W-1:0]   status;

  modport source (output valid, out_day, out_month, out_year, status, input ready);
  modport sink (input valid, out_day, out_month, out_year, status, output ready);
endinterface

// ===== design/gda_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder microsequencer
// Step counter over a read-only control store; each step issues one
// micro-operation and optionally jumps on a selected condition.
// ----------------------------------------------------------------------------
module gda_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  gda_pkg::cond_t cond,
  output gda_pkg::uop_t  uop,
  output logic           idle
);
  import gda_pkg::*;

  localparam logic [PC_W-1:0] S_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] S_DLOOP = 5'd7;
  localparam logic [PC_W-1:0] S_MLOOP = 5'd9;
  localparam logic [PC_W-1:0] S_YADD  = 5'd11;
  localparam logic [PC_W-1:0] S_SAT   = 5'd15;
  localparam logic [PC_W-1:0] S_OUT   = 5'd16;

  function automatic ctrl_t rom(input logic [PC_W-1:0] a);
    ctrl_t w;
    unique case (a)
      5'd0:    w = '{UOP_LOAD,    C_NO_INPUT,  S_IDLE};
      5'd1:    w = '{UOP_MOD,     C_NEVER,     S_IDLE};
      5'd2:    w = '{UOP_CHECK,   C_INVALID,   S_OUT};
      5'd3:    w = '{UOP_NOP,     C_OP_DAY,    S_DLOOP};
      5'd4:    w = '{UOP_NOP,     C_OP_MON,    S_MLOOP};
      5'd5:    w = '{UOP_NOP,     C_OP_YR,     S_YADD};
      5'd6:    w = '{UOP_NOP,     C_ALWAYS,    S_SAT};
      5'd7:    w = '{UOP_DAYSTEP, C_LOOP_BUSY, S_DLOOP};
      5'd8:    w = '{UOP_NOP,     C_ALWAYS,    S_SAT};
      5'd9:    w = '{UOP_MONSTEP, C_LOOP_BUSY, S_MLOOP};
      5'd10:   w = '{UOP_NOP,     C_ALWAYS,    S_SAT};
      5'd11:   w = '{UOP_YADD,    C_NEVER,     S_IDLE};
      5'd12:   w = '{UOP_YMUL,    C_NEVER,     S_IDLE};
      5'd13:   w = '{UOP_MOD,     C_NEVER,     S_IDLE};
      5'd14:   w = '{UOP_FEB,     C_NEVER,     S_IDLE};
      5'd15:   w = '{UOP_SAT,     C_NEVER,     S_IDLE};
      5'd16:   w = '{UOP_OUT,     C_OUT_BUSY,  S_OUT};
      default: w = '{UOP_NOP,     C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] upc;
  ctrl_t           ctrl;
  logic            take;

  assign ctrl = rom(upc);
  assign uop  = ctrl.uop;
  assign idle = (upc == S_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !req_valid;
      C_INVALID:   take = cond.invalid;
      C_OP_DAY:    take = cond.op_day;
      C_OP_MON:    take = cond.op_mon;
      C_OP_YR:     take = cond.op_yr;
      C_LOOP_BUSY: take = cond.loop_busy;
      C_OUT_BUSY:  take = cond.out_busy;
      default:     take = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= take ? ctrl.target : upc + 5'd1;
    end
  end

endmodule

// ===== design/gda_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder datapath
// Date registers, unit counter, year-modulo-400 tracker and the result
// register, all driven by the micro-operation of the current step.
// ----------------------------------------------------------------------------
module gda_dp #(
  parameter int unsigned AMOUNT_MAX = 65535,
  parameter int unsigned YEAR_MAX   = 9999
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gda_pkg::uop_t                uop,
  input  logic [gda_pkg::OP_W-1:0]     req_op,
  input  logic [gda_pkg::AMT_W-1:0]    req_amount,
  input  logic [gda_pkg::DAY_W-1:0]    req_day,
  input  logic [gda_pkg::MON_W-1:0]    req_month,
  input  logic [gda_pkg::YEAR_W-1:0]   req_year,
  input  logic                         rsp_ready,
  output gda_pkg::cond_t               cond,
  output logic                         res_valid,
  output logic [gda_pkg::DAY_W-1:0]    res_day,
  output logic [gda_pkg::MON_W-1:0]    res_month,
  output logic [gda_pkg::YEAR_W-1:0]   res_year,
  output logic [gda_pkg::ST_W-1:0]     res_status
);
  import gda_pkg::*;

  localparam logic [31:0]   AMAX = AMOUNT_MAX;
  localparam logic [YW-1:0] YMAX = YW'(YEAR_MAX);

  logic [OP_W-1:0]   op;
  logic [AMT_W-1:0]  amt;
  logic [DAY_W-1:0]  day;
  logic [MON_W-1:0]  month;
  logic [YW-1:0]     year;
  logic [MOD_W-1:0]  ymod;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  logic [ST_W-1:0]   st;

  logic [AMT_W-1:0]  amt_clamp;
  logic              lp;
  logic [DAY_W-1:0]  dim;
  logic              mon_wrap;
  logic [MON_W-1:0]  month_adv;
  logic [YW-1:0]     year_adv;
  logic [MOD_W-1:0]  ymod_adv;
  logic [DAY_W-1:0]  lim_adv;
  logic [CNT_W-1:0]  amt7;
  logic [YW-1:0]     amt10;
  logic [YLO_W-1:0]  ylo;
  logic [MOD_W-1:0]  quot;
  logic [YLO_W-1:0]  ydiff;
  logic              out_busy;

  assign amt_clamp = (32'(req_amount) > AMAX) ? AMAX[AMT_W-1:0] : req_amount;

  assign lp        = leap400(ymod);
  assign dim       = days_in(month, lp);
  assign mon_wrap  = (month == MON_DEC);
  assign month_adv = mon_wrap ? MON_JAN : month + 4'd1;
  assign year_adv  = mon_wrap ? year + 20'd1 : year;
  assign ymod_adv  = !mon_wrap ? ymod : ((ymod == MOD_LAST) ? 9'd0 : ymod + 9'd1);
  assign lim_adv   = days_in(month_adv, leap400(ymod_adv));

  assign amt7  = (CNT_W'(amt) << 3) - CNT_W'(amt);
  assign amt10 = (YW'(amt) << 3) + (YW'(amt) << 1);

  // Remainder after the registered reciprocal product.
  assign ylo   = year[YLO_W-1:0];
  assign quot  = prod[RECIP_SHIFT +: MOD_W];
  assign ydiff = ylo - YLO_W'(YLO_W'(quot) * CYCLE_400);

  assign out_busy = res_valid && !rsp_ready;

  assign cond.invalid   = (month < MON_JAN) || (month > MON_DEC) || (year > YMAX) ||
                          (day == 5'd0) || (day > dim);
  assign cond.op_day    = (op == OP_DAYS) || (op == OP_WEEKS);
  assign cond.op_mon    = (op == OP_MONTHS);
  assign cond.op_yr     = (op == OP_YEARS) || (op == OP_DECADES);
  assign cond.loop_busy = (cnt != '0) && (year <= YMAX);
  assign cond.out_busy  = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      // A result taken while a new one is being written is replaced below.
      if (res_valid && rsp_ready && uop != UOP_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (uop)
        UOP_NOP: begin
        end
        UOP_LOAD: begin
          op    <= req_op;
          amt   <= amt_clamp;
          day   <= req_day;
          month <= req_month;
          year  <= YW'(req_year);
          prod  <= PROD_W'(YLO_W'(req_year)) * PROD_W'(RECIP);
          st    <= ST_OK;
        end
        UOP_MOD: begin
          ymod <= ydiff[MOD_W-1:0];
        end
        UOP_CHECK: begin
          if (cond.invalid) begin
            day   <= '0;
            month <= '0;
            year  <= '0;
            st    <= ST_INVALID;
          end
          if (op == OP_WEEKS) begin
            cnt <= amt7;
          end else if (op == OP_DAYS || op == OP_MONTHS) begin
            cnt <= CNT_W'(amt);
          end else begin
            cnt <= '0;
          end
        end
        UOP_DAYSTEP: begin
          if (cond.loop_busy) begin
            cnt <= cnt - 19'd1;
            if (day >= dim) begin
              day   <= DAY_FIRST;
              month <= month_adv;
              year  <= year_adv;
              ymod  <= ymod_adv;
            end else begin
              day <= day + 5'd1;
            end
          end
        end
        UOP_MONSTEP: begin
          if (cond.loop_busy) begin
            cnt   <= cnt - 19'd1;
            month <= month_adv;
            year  <= year_adv;
            ymod  <= ymod_adv;
            if (day > lim_adv) begin
              day <= lim_adv;
            end
          end
        end
        UOP_YADD: begin
          year <= year + ((op == OP_DECADES) ? amt10 : YW'(amt));
        end
        UOP_YMUL: begin
          prod <= PROD_W'(ylo) * PROD_W'(RECIP);
        end
        UOP_FEB: begin
          if (month == MON_FEB && day == DAY_FEB_LEAP && !lp) begin
            day <= DAY_FEB_STD;
          end
        end
        UOP_SAT: begin
          if (st == ST_OK && year > YMAX) begin
            day   <= DAY_DEC_LAST;
            month <= MON_DEC;
            year  <= YMAX;
            st    <= ST_OVERFLOW;
          end
        end
        UOP_OUT: begin
          if (!out_busy) begin
            res_valid  <= 1'b1;
            res_day    <= day;
            res_month  <= month;
            res_year   <= year[YEAR_W-1:0];
            res_status <= st;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/gregorian_date_adder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder
// Adds days, weeks, months, years or decades to a proleptic Gregorian date,
// flagging invalid dates and saturating on year overflow.
// ----------------------------------------------------------------------------
// Days and weeks step the date one day at a time for the amount (times seven
// for weeks, fewer steps if the year runs past the limit); months step one
// month at a time; years and decades add the amount and recompute the year
// modulo 400; undefined operations only pass the saturation check, and an
// invalid date goes straight to the result. One calendar step is done per
// cycle in the day or month loop. After the result is registered the
// sequencer passes a spare step back to its idle step, where the next request
// is accepted. Synchronous reset returns the sequencer to its idle step and empties the result register.
// ----------------------------------------------------------------------------
module gregorian_date_adder_unit #(
  parameter int unsigned AMOUNT_MAX = 65535,
  parameter int unsigned YEAR_MAX   = 9999
) (
  input  logic       clk,
  input  logic       rst,
  gda_in_if.sink     req,
  gda_out_if.source  rsp
);
  import gda_pkg::*;

  // The sequencer walks a small control store. Its idle step loads the
  // request registers on every cycle and leaves only when a transaction is
  // offered, so ready is simply "the step counter is at the idle step".
  uop_t  uop;
  cond_t cond;
  logic  idle;

  gda_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .cond      (cond),
    .uop       (uop),
    .idle      (idle)
  );

  // The datapath holds the working date, a counter of remaining units and
  // the year modulo 400, which it keeps in step with every year increment
  // so that the leap rule never needs a divider. After a year addition the
  // remainder is recomputed through a registered reciprocal product.
  // The result register parts the two channels: a finished result waits
  // there while the sequencer goes back to fetch the next request.
  gda_dp #(
    .AMOUNT_MAX (AMOUNT_MAX),
    .YEAR_MAX   (YEAR_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .uop        (uop),
    .req_op     (req.op),
    .req_amount (req.amount),
    .req_day    (req.in_day),
    .req_month  (req.in_month),
    .req_year   (req.in_year),
    .rsp_ready  (rsp.ready),
    .cond       (cond),
    .res_valid  (rsp.valid),
    .res_day    (rsp.out_day),
    .res_month  (rsp.out_month),
    .res_year   (rsp.out_year),
    .res_status (rsp.status)
  );

  assign req.ready = idle;

endmodule
